// ----- rtl/core/rgbhsv_pkg.sv -----
// Shared types, widths and divider step function for the RGB to HSV pixel pipeline.
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

    localparam int unsigned CH_W           = 8;
    localparam int unsigned Q_W            = 8;
    localparam int unsigned REM_W          = 19;
    localparam int unsigned DEN_W          = 11;
    localparam int unsigned BITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES     = Q_W / BITS_PER_STAGE;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q;
    } t_lane;

    typedef struct packed {
        t_lane           hue;
        t_lane           sat;
        logic [CH_W-1:0] brightness;
    } t_div_state;

    function automatic t_lane lane_step(input t_lane l, input int unsigned pos);
        logic [REM_W-1:0] trial;
        t_lane            r;
        r     = l;
        trial = REM_W'(l.den) << pos;
        if (l.rem >= trial) begin
            r.rem = l.rem - trial;
            r.q   = l.q | (Q_W'(1) << pos);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rgbhsv_prep.sv -----
// Front stage: max, min, hue sector numerator and divider operands, registered.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_prep (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic                          i_valid,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]   i_red,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]   i_green,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]   i_blue,
    output logic                               o_valid,
    output rgbhsv_pkg::t_div_state             o_state
);
    import rgbhsv_pkg::*;

    logic [CH_W-1:0]  w_mx;
    logic [CH_W-1:0]  w_mn;
    logic [CH_W-1:0]  w_d;
    logic [DEN_W-1:0] w_d2;
    logic [DEN_W-1:0] w_d4;
    logic [DEN_W-1:0] w_d6;
    logic [CH_W:0]    w_x;
    logic [DEN_W-1:0] w_base;
    logic [DEN_W:0]   w_sum;
    logic [DEN_W-1:0] w_n;
    t_div_state       n_state;
    t_div_state       r_state;
    logic             r_valid;

    always_comb begin
        w_mx = (i_red > i_green) ? i_red : i_green;
        w_mx = (w_mx > i_blue) ? w_mx : i_blue;
        w_mn = (i_red < i_green) ? i_red : i_green;
        w_mn = (w_mn < i_blue) ? w_mn : i_blue;
        w_d  = w_mx - w_mn;
        w_d2 = DEN_W'(w_d) << 1;
        w_d4 = DEN_W'(w_d) << 2;
        w_d6 = w_d4 + w_d2;

        if (w_mx == i_red) begin
            w_x    = {1'b0, i_green} - {1'b0, i_blue};
            w_base = w_x[CH_W] ? w_d6 : '0;
        end else if (w_mx == i_green) begin
            w_x    = {1'b0, i_blue} - {1'b0, i_red};
            w_base = w_d2;
        end else begin
            w_x    = {1'b0, i_red} - {1'b0, i_green};
            w_base = w_d4;
        end

        w_sum = {1'b0, w_base} + {{(DEN_W-CH_W){w_x[CH_W]}}, w_x};
        w_n   = w_sum[DEN_W-1:0];

        n_state.hue.rem    = (REM_W'(w_n) << CH_W) - REM_W'(w_n);
        n_state.hue.den    = (w_d == '0) ? DEN_W'(6) : w_d6;
        n_state.hue.q      = '0;
        n_state.sat.rem    = (REM_W'(w_d) << CH_W) - REM_W'(w_d);
        n_state.sat.den    = (w_mx == '0) ? DEN_W'(1) : DEN_W'(w_mx);
        n_state.sat.q      = '0;
        n_state.brightness = w_mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
        if (i_advance) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

`default_nettype wire

// ----- rtl/core/rgbhsv_div.sv -----
// Pipelined restoring divider for hue and saturation, two quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_advance,
    input  wire logic                  i_valid,
    input  rgbhsv_pkg::t_div_state     i_state,
    output logic                       o_valid,
    output rgbhsv_pkg::t_div_state     o_state
);
    import rgbhsv_pkg::*;

    t_div_state            r_state [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_valid;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        t_div_state w_src;
        t_div_state n_state;

        if (s == 0) begin : g_first
            assign w_src = i_state;
        end else begin : g_next
            assign w_src = r_state[s-1];
        end

        always_comb begin
            n_state = w_src;
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                n_state.hue = lane_step(n_state.hue, Q_W - 1 - s * BITS_PER_STAGE - k);
                n_state.sat = lane_step(n_state.sat, Q_W - 1 - s * BITS_PER_STAGE - k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_advance) begin
                r_state[s] <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_advance) begin
            r_valid <= {r_valid[DIV_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_state = r_state[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/rgb_to_hsv_pixel.sv -----
// RGB to HSV pixel converter: top level with front stage and pipelined divider.
// Stages: 1 front stage (rgbhsv_prep), then 4 divider stages (rgbhsv_div).
// Throughput: one pixel per cycle; the whole pipe holds while a result waits.
// Reset: synchronous, active low; clears all valid bits, data registers keep contents.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_pixel (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]  i_red,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]  i_green,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]  i_blue,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [rgbhsv_pkg::Q_W-1:0]        o_hue,
    output logic [rgbhsv_pkg::Q_W-1:0]        o_saturation,
    output logic [rgbhsv_pkg::CH_W-1:0]       o_brightness
);
    import rgbhsv_pkg::*;

    logic       w_advance;
    logic       w_prep_valid;
    t_div_state w_prep_state;
    t_div_state w_out_state;

    assign w_advance = !o_valid || i_ready;
    assign o_ready   = w_advance;

    rgbhsv_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_valid   (i_valid),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_valid   (w_prep_valid),
        .o_state   (w_prep_state)
    );

    rgbhsv_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_valid   (w_prep_valid),
        .i_state   (w_prep_state),
        .o_valid   (o_valid),
        .o_state   (w_out_state)
    );

    assign o_hue        = w_out_state.hue.q;
    assign o_saturation = w_out_state.sat.q;
    assign o_brightness = w_out_state.brightness;

    a_black_no_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_brightness == '0)) |-> (o_saturation == '0))
        else $error("saturation nonzero for black pixel");

    a_gray_no_hue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_saturation == '0)) |-> (o_hue == '0))
        else $error("hue nonzero for gray pixel");

    a_hue_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue != '1))
        else $error("hue reached full scale");

    a_hold_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hue)
            && $stable(o_saturation) && $stable(o_brightness)))
        else $error("result changed while held");

endmodule

`default_nettype wire

// ----- tb/sv/tb_rgb_to_hsv_pixel.sv -----
// Testbench for rgb_to_hsv_pixel: random and corner pixels checked against an integer HSV predictor.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_pixel;

    localparam int unsigned CH_W = rgbhsv_pkg::CH_W;
    localparam int unsigned Q_W  = rgbhsv_pkg::Q_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [Q_W-1:0]  hue;
        logic [Q_W-1:0]  saturation;
        logic [CH_W-1:0] brightness;
    } t_hsv;

    class hsv_scoreboard;
        t_hsv expected_hsv[$];
        int   errors = 0;

        function t_hsv predict_hsv(t_pixel px);
            int   r, g, b, mx, mn, d, num;
            t_hsv res;
            r  = px.red;
            g  = px.green;
            b  = px.blue;
            mx = (r > g) ? r : g;
            mx = (mx > b) ? mx : b;
            mn = (r < g) ? r : g;
            mn = (mn < b) ? mn : b;
            d  = mx - mn;
            res.brightness = CH_W'(mx);
            res.saturation = (mx != 0) ? Q_W'((d * 255) / mx) : '0;
            res.hue        = '0;
            if (d != 0) begin
                if (mx == r) begin
                    num = 60 * (g - b);
                end else if (mx == g) begin
                    num = 120 * d + 60 * (b - r);
                end else begin
                    num = 240 * d + 60 * (r - g);
                end
                if (num < 0) begin
                    num += 360 * d;
                end
                res.hue = Q_W'((num * 255) / (360 * d));
            end
            return res;
        endfunction

        function void note_request(t_pixel px);
            expected_hsv.push_back(predict_hsv(px));
        endfunction

        function void check_result(t_hsv got);
            t_hsv want;
            if (expected_hsv.size() == 0) begin
                $error("result with no request pending: hue %0d saturation %0d brightness %0d",
                       got.hue, got.saturation, got.brightness);
                errors++;
                return;
            end
            want = expected_hsv.pop_front();
            if (got.hue !== want.hue) begin
                $error("hue: expected %0d, actual %0d", want.hue, got.hue);
                errors++;
            end
            if (got.saturation !== want.saturation) begin
                $error("saturation: expected %0d, actual %0d", want.saturation, got.saturation);
                errors++;
            end
            if (got.brightness !== want.brightness) begin
                $error("brightness: expected %0d, actual %0d", want.brightness, got.brightness);
                errors++;
            end
        endfunction

        function int expected_count();
            return expected_hsv.size();
        endfunction
    endclass

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic [CH_W-1:0] i_red   = '0;
    logic [CH_W-1:0] i_green = '0;
    logic [CH_W-1:0] i_blue  = '0;
    logic            i_ready = 1'b0;
    logic            o_ready;
    logic            o_valid;
    logic [Q_W-1:0]  o_hue;
    logic [Q_W-1:0]  o_saturation;
    logic [CH_W-1:0] o_brightness;

    hsv_scoreboard board = new();
    int            results_seen = 0;
    int            hold_left    = 0;

    rgb_to_hsv_pixel i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always #2 i_clk = ~i_clk;

    // check results; hold off for a long stretch twice so the pipe fills and stalls requests
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            board.check_result('{o_hue, o_saturation, o_brightness});
            results_seen++;
            if (results_seen == 300 || results_seen == 1300) begin
                hold_left = 60;
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (results_seen >= 600 && results_seen < 900) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 13);
        end
    end

    function automatic t_pixel random_pixel();
        t_pixel          px;
        logic [CH_W-1:0] a, b;
        logic [CH_W-1:0] corner [4] = '{8'd0, 8'd255, 8'd1, 8'd254};
        a = CH_W'($urandom);
        b = CH_W'($urandom);
        case ($urandom_range(9))
            0: px = '{a, a, a};
            1: begin
                case ($urandom_range(2))
                    0: px = '{a, a, b};
                    1: px = '{a, b, a};
                    default: px = '{b, a, a};
                endcase
            end
            2: px = '{corner[$urandom_range(3)], corner[$urandom_range(3)],
                      corner[$urandom_range(3)]};
            default: px = '{a, b, CH_W'($urandom)};
        endcase
        return px;
    endfunction

    task automatic send_pixel(input t_pixel px);
        i_valid <= 1'b1;
        i_red   <= px.red;
        i_green <= px.green;
        i_blue  <= px.blue;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        board.note_request(px);
    endtask

    task automatic sender_gap(input bit may_idle);
        while (may_idle && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_count() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [3*CH_W-1:0] corner_rgb [$];
        int                n;
        corner_rgb = '{
            24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
            24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010000, 24'h000001,
            24'h000100, 24'h808080, 24'hFF0001, 24'hFF0100, 24'h0001FF,
            24'h01FF00, 24'hFE00FF, 24'hFFFEFE, 24'h010100, 24'h000101,
            24'h7F80FF, 24'hAA55AA, 24'h01FFFE
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (corner_rgb[k]) begin
            send_pixel(t_pixel'(corner_rgb[k]));
            sender_gap(1'b1);
        end
        drain_results();
        for (n = 0; n < 1800; n++) begin
            send_pixel(random_pixel());
            if (n == 1000) begin
                drain_results();
            end else begin
                sender_gap(!(n >= 600 && n < 900));
            end
        end
        drain_results();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.expected_count() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
